### sv/category_fifo_with_eviction_core_defines.svh
// ----------------------------------------------------------------------------
// Category FIFO with eviction: assertion macros
// Shared concurrent assertion forms. Both expect signals named clock and reset.
// ----------------------------------------------------------------------------
`ifndef CATEGORY_FIFO_WITH_EVICTION_CORE_DEFINES_SVH
`define CATEGORY_FIFO_WITH_EVICTION_CORE_DEFINES_SVH

// Checked on every clock edge outside of reset.
`define CFE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define CFE_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### sv/cfe_pkg.sv
// ----------------------------------------------------------------------------
// Category FIFO with eviction: package
// Sizes, request and result types, operation codes and slot arithmetic.
// ----------------------------------------------------------------------------
package cfe_pkg;

   localparam int DEPTH      = 32;
   localparam int CATEGORIES = 4;
   localparam int NREGS      = 4;
   localparam int LIMIT_W    = 7;
   localparam int HANDLE_W   = 32;
   localparam int CAT_W      = 2;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int SLOT_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ADDR_W     = (CATEGORIES * DEPTH > 1) ? $clog2(CATEGORIES * DEPTH) : 1;
   localparam int INDEX_W    = (NREGS > 1) ? $clog2(NREGS) : 1;
   localparam int WORDS      = CATEGORIES * DEPTH;

   localparam logic [LIMIT_W-1:0] RESET_LIMIT = LIMIT_W'(32);
   localparam logic [CNT_W-1:0]   DEPTH_CNT   = CNT_W'(DEPTH);

   localparam logic OP_ADD      = 1'b0;
   localparam logic OP_REMOVE   = 1'b1;
   localparam logic KIND_EVICT  = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   typedef struct packed {
      logic                operation;
      logic [CAT_W-1:0]    category;
      logic [HANDLE_W-1:0] handle;
   } req_type;

   typedef struct packed {
      logic                result_kind;
      logic [CAT_W-1:0]    category_out;
      logic [HANDLE_W-1:0] handle_out;
      logic                found;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic             disabled;
      logic [CNT_W-1:0] value;
   } lim_type;

   // Ring position of the entry at a given offset from the head.
   // Callers keep the offset at or below DEPTH, so one subtraction wraps it.
   function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] head,
                                                 input logic [CNT_W-1:0]  off);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(head) + (CNT_W+1)'(off);
      if (sum >= (CNT_W+1)'(DEPTH)) begin
         sum = sum - (CNT_W+1)'(DEPTH);
      end
      return SLOT_W'(sum);
   endfunction

   function automatic logic [ADDR_W-1:0] mem_addr(input logic [CAT_W-1:0]  cat,
                                                  input logic [SLOT_W-1:0] slot);
      return ADDR_W'(32'(cat) * DEPTH + 32'(slot));
   endfunction

   // Negative limits disable adds; limits beyond DEPTH saturate.
   function automatic lim_type eff_limit(input logic [LIMIT_W-1:0] raw);
      lim_type l;
      l.disabled = raw[LIMIT_W-1];
      if (32'(raw[LIMIT_W-2:0]) > DEPTH) begin
         l.value = DEPTH_CNT;
      end else begin
         l.value = CNT_W'(raw[LIMIT_W-2:0]);
      end
      return l;
   endfunction

endpackage

### sv/category_fifo_with_eviction_core.sv
// ----------------------------------------------------------------------------
// Category FIFO with eviction core
// An add with E evictions streams E eviction reports, one report per cycle,
// and with a zero limit the new handle is reported after them. A remove
// streams the search and then the compaction through one RAM read port.
// Results appear in the cycle after they are formed.
// Reset clears the counts, the heads and sets every limit to 32; the entry RAM
// is not cleared.
// ----------------------------------------------------------------------------
module category_fifo_with_eviction_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  cfe_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   output cfe_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [cfe_pkg::INDEX_W-1:0]         csr_index,
   input  logic [cfe_pkg::LIMIT_W-1:0]         csr_wdata
);

   logic [cfe_pkg::NREGS-1:0][cfe_pkg::LIMIT_W-1:0] limit_ff;

   // Limit registers, one per category.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < cfe_pkg::NREGS; r++) begin
            limit_ff[r] <= cfe_pkg::RESET_LIMIT;
         end
      end else if (csr_we) begin
         limit_ff[csr_index] <= csr_wdata;
      end
   end

   cfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .limits    (limit_ff),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

### sv/cfe_ram.sv
// ----------------------------------------------------------------------------
// Category FIFO with eviction: entry RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cfe_ram #(
   parameter int WIDTH = 32,
   parameter int WORDS = 128,
   parameter int AW    = 7
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [WORDS];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### sv/cfe_ctrl.sv
// ----------------------------------------------------------------------------
// Category FIFO with eviction: queue controller
// Sequences each request against the entry RAM: streaming search and
// compaction for removes, streaming eviction and append for adds.
// ----------------------------------------------------------------------------
`include "category_fifo_with_eviction_core_defines.svh"

module cfe_ctrl (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  cfe_pkg::req_type                         req_data,
   input  logic [cfe_pkg::NREGS-1:0][cfe_pkg::LIMIT_W-1:0] limits,
   output logic                                     rsp_valid,
   output cfe_pkg::rsp_type                         rsp_data
);

   localparam int CW = cfe_pkg::CNT_W;
   localparam int SW = cfe_pkg::SLOT_W;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_LOAD  = 3'd1;
   localparam logic [2:0] ST_SRCH  = 3'd2;
   localparam logic [2:0] ST_CMPCT = 3'd3;
   localparam logic [2:0] ST_EVICT = 3'd4;
   localparam logic [2:0] ST_EVNEW = 3'd5;

   logic [2:0]             state_ff, state_in;
   cfe_pkg::req_type       req_ff, req_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic [SW-1:0]          head_ff, head_in;
   logic [CW-1:0]          lim_ff, lim_in;
   logic [CW-1:0]          issue_ff, issue_in;
   logic                   dv_ff, dv_in;
   logic [CW-1:0]          didx_ff, didx_in;
   logic [CW-1:0]          nev_ff, nev_in;
   logic [CW-1:0]          j_ff, j_in;
   logic [CW-1:0]          cat_cnt_ff [cfe_pkg::CATEGORIES];
   logic [SW-1:0]          cat_head_ff [cfe_pkg::CATEGORIES];
   logic                   rsp_valid_ff;
   cfe_pkg::rsp_type       rsp_ff;

   logic                   commit;
   logic [CW-1:0]          commit_cnt;
   logic [SW-1:0]          commit_head;
   logic                   emit;
   cfe_pkg::rsp_type       emit_rsp;

   logic                   mem_we;
   logic [cfe_pkg::ADDR_W-1:0]   mem_waddr;
   logic [cfe_pkg::HANDLE_W-1:0] mem_wdata;
   logic                   mem_re;
   logic [cfe_pkg::ADDR_W-1:0]   mem_raddr;
   logic [cfe_pkg::HANDLE_W-1:0] rd_data;

   logic                   present;
   logic [CW-1:0]          ld_cnt;
   logic [SW-1:0]          ld_head;
   cfe_pkg::lim_type       ld_lim;
   logic [CW-1:0]          ld_ev;
   logic                   ev_last;

   cfe_ram #(
      .WIDTH (cfe_pkg::HANDLE_W),
      .WORDS (cfe_pkg::WORDS),
      .AW    (cfe_pkg::ADDR_W)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (rd_data)
   );

   assign present = 32'(req_ff.category) < cfe_pkg::CATEGORIES;
   assign ld_cnt  = cat_cnt_ff[req_ff.category];
   assign ld_head = cat_head_ff[req_ff.category];
   assign ld_lim  = cfe_pkg::eff_limit(limits[req_ff.category]);
   assign ev_last = (didx_ff == nev_ff - CW'(1));

   // Number of stored entries an add pushes out. With a zero limit the whole
   // queue goes, and the new handle is reported after it.
   always_comb begin
      if (ld_cnt >= ld_lim.value) begin
         if (ld_lim.value == '0) begin
            ld_ev = ld_cnt;
         end else begin
            ld_ev = ld_cnt - ld_lim.value + CW'(1);
         end
      end else begin
         ld_ev = '0;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_in      = req_ff;
      cnt_in      = cnt_ff;
      head_in     = head_ff;
      lim_in      = lim_ff;
      issue_in    = issue_ff;
      dv_in       = 1'b0;
      didx_in     = didx_ff;
      nev_in      = nev_ff;
      j_in        = j_ff;
      commit      = 1'b0;
      commit_cnt  = cnt_ff;
      commit_head = head_ff;
      mem_we      = 1'b0;
      mem_waddr   = cfe_pkg::mem_addr(req_ff.category, cfe_pkg::slot_of(head_ff, cnt_ff));
      mem_wdata   = req_ff.handle;
      mem_re      = 1'b0;
      mem_raddr   = cfe_pkg::mem_addr(req_ff.category, cfe_pkg::slot_of(head_ff, issue_ff));
      emit        = 1'b0;
      emit_rsp.result_kind  = cfe_pkg::KIND_EVICT;
      emit_rsp.category_out = req_ff.category;
      emit_rsp.handle_out   = req_ff.handle;
      emit_rsp.found        = 1'b0;
      emit_rsp.last         = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in   = req_data;
               state_in = ST_LOAD;
            end
         end

         ST_LOAD: begin
            cnt_in   = ld_cnt;
            head_in  = ld_head;
            lim_in   = ld_lim.value;
            nev_in   = ld_ev;
            issue_in = '0;
            j_in     = '0;
            state_in = ST_IDLE;
            if (req_ff.operation == cfe_pkg::OP_REMOVE) begin
               if (!present || req_ff.handle == '0 || ld_cnt == '0) begin
                  emit                 = 1'b1;
                  emit_rsp.result_kind = cfe_pkg::KIND_REMOVE;
                  emit_rsp.last        = 1'b1;
               end else begin
                  state_in = ST_SRCH;
               end
            end else if (present && req_ff.handle != '0 && !ld_lim.disabled) begin
               if (ld_lim.value == '0 && ld_cnt == '0) begin
                  state_in = ST_EVNEW;
               end else if (ld_ev == '0) begin
                  mem_we      = 1'b1;
                  mem_waddr   = cfe_pkg::mem_addr(req_ff.category,
                                                  cfe_pkg::slot_of(ld_head, ld_cnt));
                  commit      = 1'b1;
                  commit_cnt  = ld_cnt + CW'(1);
                  commit_head = ld_head;
               end else begin
                  state_in = ST_EVICT;
               end
            end
         end

         // One read issued per cycle; the compare runs in the cycle after its read is issued.
         ST_SRCH: begin
            mem_re   = 1'b1;
            issue_in = issue_ff + CW'(1);
            dv_in    = 1'b1;
            didx_in  = issue_ff;
            if (dv_ff && rd_data == req_ff.handle) begin
               j_in     = didx_ff;
               state_in = ST_CMPCT;
            end else if (dv_ff && (didx_ff + CW'(1)) == cnt_ff) begin
               emit                 = 1'b1;
               emit_rsp.result_kind = cfe_pkg::KIND_REMOVE;
               emit_rsp.last        = 1'b1;
               state_in             = ST_IDLE;
            end
         end

         // Read data holds the entry after j; it moves down into j while the
         // entry after that is fetched.
         ST_CMPCT: begin
            if (j_ff < cnt_ff - CW'(1)) begin
               mem_we    = 1'b1;
               mem_waddr = cfe_pkg::mem_addr(req_ff.category,
                                             cfe_pkg::slot_of(head_ff, j_ff));
               mem_wdata = rd_data;
               mem_re    = 1'b1;
               mem_raddr = cfe_pkg::mem_addr(req_ff.category,
                                             cfe_pkg::slot_of(head_ff, CW'(32'(j_ff) + 2)));
               j_in      = j_ff + CW'(1);
            end else begin
               commit               = 1'b1;
               commit_cnt           = cnt_ff - CW'(1);
               commit_head          = head_ff;
               emit                 = 1'b1;
               emit_rsp.result_kind = cfe_pkg::KIND_REMOVE;
               emit_rsp.found       = 1'b1;
               emit_rsp.last        = 1'b1;
               state_in             = ST_IDLE;
            end
         end

         ST_EVICT: begin
            if (issue_ff < nev_ff) begin
               mem_re   = 1'b1;
               issue_in = issue_ff + CW'(1);
               dv_in    = 1'b1;
               didx_in  = issue_ff;
            end
            if (dv_ff) begin
               emit                = 1'b1;
               emit_rsp.handle_out = rd_data;
               emit_rsp.last       = ev_last && lim_ff != '0;
               if (ev_last) begin
                  if (lim_ff == '0) begin
                     state_in = ST_EVNEW;
                  end else begin
                     mem_we      = 1'b1;
                     commit      = 1'b1;
                     commit_cnt  = cnt_ff - nev_ff + CW'(1);
                     commit_head = cfe_pkg::slot_of(head_ff, nev_ff);
                     state_in    = ST_IDLE;
                  end
               end
            end
         end

         // Zero limit: the new handle itself is reported and not stored.
         ST_EVNEW: begin
            emit          = 1'b1;
            emit_rsp.last = 1'b1;
            commit        = 1'b1;
            commit_cnt    = '0;
            commit_head   = cfe_pkg::slot_of(head_ff, cnt_ff);
            state_in      = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         dv_ff        <= 1'b0;
         for (int c = 0; c < cfe_pkg::CATEGORIES; c++) begin
            cat_cnt_ff[c]  <= '0;
            cat_head_ff[c] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= emit;
         dv_ff        <= dv_in;
         if (commit) begin
            cat_cnt_ff[req_ff.category]  <= commit_cnt;
            cat_head_ff[req_ff.category] <= commit_head;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      cnt_ff   <= cnt_in;
      head_ff  <= head_in;
      lim_ff   <= lim_in;
      issue_ff <= issue_in;
      didx_ff  <= didx_in;
      nev_ff   <= nev_in;
      j_ff     <= j_in;
      rsp_ff   <= emit_rsp;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `CFE_ASSERT(a_accept_loads, start && !busy |=> state_ff == ST_LOAD, "request accepted but not loaded")
   `CFE_ASSERT(a_more_follows, rsp_valid_ff && !rsp_ff.last |-> state_ff != ST_IDLE, "idle before last result")
   `CFE_ASSERT(a_cnt_bound, state_ff != ST_IDLE && state_ff != ST_LOAD |-> cnt_ff <= cfe_pkg::DEPTH_CNT, "entry count above depth")
   `CFE_ASSERT(a_write_phase, mem_we |-> state_ff == ST_LOAD || state_ff == ST_CMPCT || state_ff == ST_EVICT, "RAM write outside an update step")
   `CFE_ASSERT(a_found_kind, rsp_valid_ff && rsp_ff.found |-> rsp_ff.result_kind == cfe_pkg::KIND_REMOVE, "found set on an eviction report")
   `CFE_ASSERT_RST(a_reset_idle, reset |=> state_ff == ST_IDLE && !rsp_valid_ff, "not idle after reset")

endmodule

### test/cfe_tb_pkg.sv
// ----------------------------------------------------------------------------
// Category FIFO with eviction: scoreboard package
// Tracks each category queue as a ring, works out the eviction reports and
// remove replies that every accepted request must cause, and checks the
// results against them in order.
// ----------------------------------------------------------------------------
package cfe_tb_pkg;

   import cfe_pkg::*;

   class queue_tracker;

      logic [HANDLE_W-1:0] slots [CATEGORIES][DEPTH];
      int unsigned         count [CATEGORIES];
      int unsigned         head  [CATEGORIES];
      logic [LIMIT_W-1:0]  limit [NREGS];
      rsp_type             awaited [$];
      int                  errors;

      function new();
         for (int c = 0; c < CATEGORIES; c++) begin
            count[c] = 0;
            head[c]  = 0;
         end
         for (int r = 0; r < NREGS; r++) begin
            limit[r] = RESET_LIMIT;
         end
         errors = 0;
      endfunction

      function void set_limit(input int idx, input logic [LIMIT_W-1:0] value);
         limit[idx] = value;
      endfunction

      // Returns -1 when adds are disabled, otherwise the limit capped at DEPTH.
      function int usable_limit(input logic [CAT_W-1:0] cat);
         int v;
         v = int'(limit[cat]);
         if (limit[cat][LIMIT_W-1]) begin
            v = v - (1 << LIMIT_W);
         end
         if (v < 0) begin
            return -1;
         end
         if (v > DEPTH) begin
            return DEPTH;
         end
         return v;
      endfunction

      // A handle currently held in the category, or null when it is empty.
      function logic [HANDLE_W-1:0] pick_held(input logic [CAT_W-1:0] cat);
         if (count[cat] == 0) begin
            return '0;
         end
         return slots[cat][(head[cat] + $urandom_range(count[cat] - 1)) % DEPTH];
      endfunction

      function void push_result(input logic kind, input logic [CAT_W-1:0] cat,
                                input logic [HANDLE_W-1:0] h, input logic hit,
                                input logic fin);
         rsp_type r;
         r.result_kind  = kind;
         r.category_out = cat;
         r.handle_out   = h;
         r.found        = hit;
         r.last         = fin;
         awaited.push_back(r);
      endfunction

      function void note_request(input req_type req);
         logic [CAT_W-1:0]    c;
         logic [HANDLE_W-1:0] h;
         int unsigned         i;
         int unsigned         j;
         int                  lim;
         int                  made;
         bit                  hit;
         bit                  kept;
         c = req.category;
         h = req.handle;
         if (req.operation == OP_REMOVE) begin
            hit = 1'b0;
            i   = 0;
            while (i < count[c] && !hit) begin
               if (slots[c][(head[c] + i) % DEPTH] == h) begin
                  hit = 1'b1;
               end else begin
                  i++;
               end
            end
            // No entry is ever null, so a null remove never matches.
            if (h == '0) begin
               hit = 1'b0;
            end
            if (hit) begin
               for (j = i; j + 1 < count[c]; j++) begin
                  slots[c][(head[c] + j) % DEPTH] = slots[c][(head[c] + j + 1) % DEPTH];
               end
               count[c]--;
            end
            push_result(KIND_REMOVE, c, h, hit, 1'b1);
            return;
         end
         if (h == '0) begin
            return;
         end
         lim = usable_limit(c);
         if (lim < 0) begin
            return;
         end
         made = 0;
         kept = 1'b1;
         // The new handle counts as present while the oldest are evicted.
         while (kept && int'(count[c]) + 1 > lim) begin
            if (count[c] > 0) begin
               push_result(KIND_EVICT, c, slots[c][head[c]], 1'b0, 1'b0);
               head[c] = (head[c] + 1) % DEPTH;
               count[c]--;
            end else begin
               push_result(KIND_EVICT, c, h, 1'b0, 1'b0);
               kept = 1'b0;
            end
            made++;
         end
         if (kept) begin
            slots[c][(head[c] + count[c]) % DEPTH] = h;
            count[c]++;
         end
         if (made > 0) begin
            awaited[awaited.size() - 1].last = 1'b1;
         end
      endfunction

      task report(input string what);
         errors++;
         $display("mismatch at %0t: %s", $realtime, what);
      endtask

      task check_result(input rsp_type got);
         rsp_type want;
         if (awaited.size() == 0) begin
            report($sformatf("result %h with nothing pending", got));
            return;
         end
         want = awaited.pop_front();
         if (got.result_kind !== want.result_kind) begin
            report($sformatf("result_kind %b, wanted %b", got.result_kind, want.result_kind));
         end
         if (got.category_out !== want.category_out) begin
            report($sformatf("category_out %0d, wanted %0d", got.category_out,
                             want.category_out));
         end
         if (got.handle_out !== want.handle_out) begin
            report($sformatf("handle_out %h, wanted %h", got.handle_out, want.handle_out));
         end
         if (got.found !== want.found) begin
            report($sformatf("found %b, wanted %b", got.found, want.found));
         end
         if (got.last !== want.last) begin
            report($sformatf("last %b, wanted %b", got.last, want.last));
         end
      endtask

   endclass

endpackage

### test/tb_top.sv
// ----------------------------------------------------------------------------
// Category FIFO with eviction: testbench top
// Drives add and remove requests through the start/busy handshake, sets the
// limit registers between phases, and checks every result strobe against the
// scoreboard. Directed cases come first, then a queue fill to the largest
// eviction burst, then random phases under varied sender idling.
// ----------------------------------------------------------------------------
module tb_top;

   import cfe_pkg::*;
   import cfe_tb_pkg::*;

   localparam logic [LIMIT_W-1:0] LIM_OFF  = 7'h7F;
   localparam logic [LIMIT_W-1:0] LIM_ZERO = 7'd0;
   localparam logic [LIMIT_W-1:0] LIM_ONE  = 7'd1;
   localparam logic [LIMIT_W-1:0] LIM_FULL = 7'd32;
   localparam int                 POOL_N   = 12;

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                start     = 1'b0;
   logic                busy;
   req_type             req_data  = '0;
   logic                rsp_valid;
   rsp_type             rsp_data;
   logic                csr_we    = 1'b0;
   logic [INDEX_W-1:0]  csr_index = '0;
   logic [LIMIT_W-1:0]  csr_wdata = '0;

   queue_tracker        tracker = new();
   int                  idle_pct = 0;
   logic [HANDLE_W-1:0] pool [POOL_N];

   always #6 clock = ~clock;

   category_fifo_with_eviction_core uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Results are checked before the request of the same edge is noted, since a
   // result leaving now always belongs to an earlier request.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            tracker.check_result(rsp_data);
         end
         if (start && !busy) begin
            tracker.note_request(req_data);
         end
      end
   end

   task automatic send_request(input logic op, input logic [CAT_W-1:0] cat,
                               input logic [HANDLE_W-1:0] h);
      int      gap;
      req_type r;
      gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 12) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      r.operation = op;
      r.category  = cat;
      r.handle    = h;
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // Lets the block drain, then waits out its tail so a register write finds it
   // idle even after a request that produced nothing.
   task automatic settle();
      int waited;
      start  <= 1'b0;
      waited = 0;
      while (tracker.awaited.size() != 0 && waited < 4000) begin
         @(negedge clock);
         waited++;
      end
      if (tracker.awaited.size() != 0) begin
         tracker.report($sformatf("%0d expected results never arrived",
                                  tracker.awaited.size()));
         tracker.awaited.delete();
      end
      while (busy) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_limits(input logic [LIMIT_W-1:0] l0, input logic [LIMIT_W-1:0] l1,
                               input logic [LIMIT_W-1:0] l2, input logic [LIMIT_W-1:0] l3);
      logic [LIMIT_W-1:0] vals [NREGS];
      vals[0] = l0;
      vals[1] = l1;
      vals[2] = l2;
      vals[3] = l3;
      for (int i = 0; i < NREGS; i++) begin
         csr_we    <= 1'b1;
         csr_index <= INDEX_W'(i);
         csr_wdata <= vals[i];
         @(negedge clock);
         tracker.set_limit(i, vals[i]);
      end
      csr_we <= 1'b0;
   endtask

   function automatic logic [LIMIT_W-1:0] random_limit();
      case ($urandom_range(5))
         0:       return LIM_OFF;
         1:       return LIM_ZERO;
         2:       return LIMIT_W'($urandom_range(1, 4));
         3:       return LIMIT_W'($urandom_range(0, 32));
         4:       return LIMIT_W'($urandom_range(1, 2));
         default: return LIM_FULL;
      endcase
   endfunction

   function automatic logic [HANDLE_W-1:0] random_handle();
      int k;
      k = $urandom_range(99);
      if (k < 8) begin
         return '0;
      end
      if (k < 20) begin
         return $urandom();
      end
      return pool[$urandom_range(POOL_N - 1)];
   endfunction

   function automatic logic [HANDLE_W-1:0] nonzero_handle();
      logic [HANDLE_W-1:0] h;
      h = $urandom();
      if (h == '0) begin
         h = 32'h1;
      end
      return h;
   endfunction

   // Adds draw from a small pool so that removes often hit; most removes ask
   // for a handle that is really held.
   task automatic random_phase(input int n);
      logic [CAT_W-1:0]    cat;
      logic [HANDLE_W-1:0] h;
      for (int i = 0; i < n; i++) begin
         cat = CAT_W'($urandom_range(CATEGORIES - 1));
         if ($urandom_range(99) < 60) begin
            send_request(OP_ADD, cat, random_handle());
         end else begin
            h = ($urandom_range(99) < 70) ? tracker.pick_held(cat) : random_handle();
            send_request(OP_REMOVE, cat, h);
         end
      end
   endtask

   initial begin
      #(12 * 400000);
      $display("tb_top: FAIL");
      $finish;
   end

   initial begin
      for (int i = 0; i < POOL_N; i++) begin
         pool[i] = nonzero_handle();
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed requests with every limit at its reset value.
      idle_pct = 0;
      send_request(OP_ADD,    2'd0, 32'h0000_0000);
      send_request(OP_REMOVE, 2'd0, 32'h0000_0000);
      send_request(OP_ADD,    2'd0, 32'hFFFF_FFFF);
      send_request(OP_ADD,    2'd0, 32'h0000_0001);
      send_request(OP_ADD,    2'd0, 32'hAAAA_AAAA);
      send_request(OP_ADD,    2'd0, 32'h5555_5555);
      send_request(OP_REMOVE, 2'd0, 32'hAAAA_AAAA);
      send_request(OP_REMOVE, 2'd0, 32'hAAAA_AAAA);
      send_request(OP_REMOVE, 2'd3, 32'h1234_5678);
      send_request(OP_ADD,    2'd1, 32'h0000_FFFF);
      send_request(OP_ADD,    2'd1, 32'hFFFF_0000);
      send_request(OP_ADD,    2'd2, 32'h8000_0000);
      send_request(OP_ADD,    2'd3, 32'h7FFF_FFFF);
      settle();

      // A lowered limit evicts on the next add, a zero limit reports the new
      // handle itself, and a disabled category still serves removes.
      write_limits(LIM_ONE, LIM_ZERO, LIM_OFF, LIM_FULL);
      send_request(OP_ADD,    2'd0, 32'h1357_9BDF);
      send_request(OP_ADD,    2'd1, 32'h2468_ACE0);
      send_request(OP_ADD,    2'd2, 32'hCAFE_F00D);
      send_request(OP_REMOVE, 2'd2, 32'h8000_0000);
      send_request(OP_ADD,    2'd1, 32'h0000_0000);
      send_request(OP_REMOVE, 2'd0, 32'h1357_9BDF);
      settle();

      // Fill category 3 to the full depth, overflow it once, then drop its
      // limit to zero for the longest burst of reports.
      write_limits(LIM_FULL, LIM_FULL, LIM_FULL, LIM_FULL);
      idle_pct = 23;
      for (int i = 0; i < DEPTH; i++) begin
         send_request(OP_ADD, 2'd3, nonzero_handle());
      end
      settle();
      write_limits(LIM_FULL, LIM_FULL, LIM_FULL, LIM_ZERO);
      send_request(OP_ADD, 2'd3, nonzero_handle());
      settle();

      idle_pct = 0;
      write_limits(random_limit(), random_limit(), random_limit(), random_limit());
      random_phase(20);
      settle();
      idle_pct = 80;
      write_limits(random_limit(), random_limit(), random_limit(), random_limit());
      random_phase(20);
      settle();
      idle_pct = 23;
      write_limits(random_limit(), random_limit(), random_limit(), random_limit());
      random_phase(20);
      settle();
      idle_pct = 0;
      write_limits(LIM_OFF, LIM_FULL, LIMIT_W'($urandom_range(1, 3)), random_limit());
      random_phase(20);
      settle();

      if (tracker.errors == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+sv
sv/cfe_pkg.sv
sv/cfe_ram.sv
sv/cfe_ctrl.sv
sv/category_fifo_with_eviction_core.sv
test/cfe_tb_pkg.sv
test/tb_top.sv
